// ===== hdl/t4te_pkg.sv =====
package t4te_pkg;

    localparam int LINE_W   = 32;
    localparam int NIBBLE_W = 4;
    localparam int PIXELS   = LINE_W / NIBBLE_W;
    localparam int MODE_W   = 3;
    localparam int SHIFT_W  = 4;
    localparam int APB_W    = 32;
    localparam int ADDR_W   = 3;

    // Register indexes, selected by paddr[2].
    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_SHIFT = 1'b1;

    // Transform mode codes.
    localparam logic [MODE_W-1:0] MODE_PASS    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_OR      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SHL     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SHR     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FLIP_V  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_FLIP_H  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_FLIP_VH = 3'd6;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [SHIFT_W-1:0] shift;
    } tile_cfg_t;

    typedef struct packed {
        logic shift_fwd;
        logic shift_rev;
    } cell_ctrl_t;

endpackage

// ===== hdl/t4te_cell.sv =====
module t4te_cell
(
    input  logic                          clk,
    input  t4te_pkg::cell_ctrl_t          ctrl,
    input  logic [t4te_pkg::LINE_W-1:0]   prev_line,
    input  logic [t4te_pkg::LINE_W-1:0]   prev_partner,
    input  logic [t4te_pkg::LINE_W-1:0]   next_line,
    input  logic [t4te_pkg::LINE_W-1:0]   next_partner,
    output logic [t4te_pkg::LINE_W-1:0]   line,
    output logic [t4te_pkg::LINE_W-1:0]   partner
);

    logic [t4te_pkg::LINE_W-1:0] line_reg;
    logic [t4te_pkg::LINE_W-1:0] line_next;
    logic [t4te_pkg::LINE_W-1:0] partner_reg;
    logic [t4te_pkg::LINE_W-1:0] partner_next;

    always_comb
    begin
        line_next    = line_reg;
        partner_next = partner_reg;
        if (ctrl.shift_fwd)
        begin
            line_next    = prev_line;
            partner_next = prev_partner;
        end
        else if (ctrl.shift_rev)
        begin
            line_next    = next_line;
            partner_next = next_partner;
        end
    end

    always_ff @(posedge clk)
    begin
        line_reg    <= line_next;
        partner_reg <= partner_next;
    end

    assign line    = line_reg;
    assign partner = partner_reg;

endmodule

// ===== hdl/t4te_xform.sv =====
module t4te_xform
(
    input  t4te_pkg::tile_cfg_t           cfg,
    input  logic [t4te_pkg::LINE_W-1:0]   fwd_line,
    input  logic [t4te_pkg::LINE_W-1:0]   fwd_partner,
    input  logic [t4te_pkg::LINE_W-1:0]   rev_line,
    output logic [t4te_pkg::LINE_W-1:0]   result
);

    localparam int SHAMT_W = t4te_pkg::SHIFT_W + 1;

    logic [t4te_pkg::LINE_W-1:0] rev_nibbles;
    logic [SHAMT_W-1:0]          bit_shift;
    logic                        shift_clear;

    // Reversing the nibbles of the far-end line serves both horizontal flips:
    // for the plain horizontal flip the far end is never selected, so it is
    // taken from the forward head instead.
    logic [t4te_pkg::LINE_W-1:0] flip_src;

    assign flip_src = (cfg.mode == t4te_pkg::MODE_FLIP_VH) ? rev_line : fwd_line;

    always_comb
    begin
        for (int p = 0; p < t4te_pkg::PIXELS; p++)
        begin
            rev_nibbles[p*t4te_pkg::NIBBLE_W +: t4te_pkg::NIBBLE_W] =
                flip_src[(t4te_pkg::PIXELS-1-p)*t4te_pkg::NIBBLE_W +: t4te_pkg::NIBBLE_W];
        end
    end

    // Eight or more pixels shift every pixel out of the line.
    assign shift_clear = cfg.shift[t4te_pkg::SHIFT_W-1];
    assign bit_shift   = {cfg.shift[t4te_pkg::SHIFT_W-2:0], 2'b00};

    always_comb
    begin
        case (cfg.mode)
            t4te_pkg::MODE_OR:
                result = fwd_line | fwd_partner;
            t4te_pkg::MODE_SHL:
                result = shift_clear ? '0 : (fwd_line >> bit_shift);
            t4te_pkg::MODE_SHR:
                result = shift_clear ? '0 : (fwd_line << bit_shift);
            t4te_pkg::MODE_FLIP_V:
                result = rev_line;
            t4te_pkg::MODE_FLIP_H, t4te_pkg::MODE_FLIP_VH:
                result = rev_nibbles;
            default:
                result = fwd_line;
        endcase
    end

endmodule

// ===== hdl/tile_4bpp_transform_engine.sv =====
// Tile transform engine for 8x8 tiles of 4-bit pixels. One transaction on the
// tile channel delivers a tile line and its partner line; they enter a chain of
// line cells that holds the whole tile. Loading takes one cycle per line. When
// the eighth line is accepted the mode and shift registers are latched for the
// tile, tile_stall rises, and, while the output is not stalled, the chain
// shifts one line per cycle toward the output register (from the far end for
// the vertical flips), so eight results follow, the eighth with last_line set.
// The cell chain holds one tile at a time, so the next tile is held off until
// the last line of this one has left the chain. The first line of the next
// tile may be accepted while the last result still waits in the output
// register. No clearing pass is needed after reset.
module tile_4bpp_transform_engine
#(
    parameter int TILE_LINES = 8
)
(
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [t4te_pkg::ADDR_W-1:0]        paddr,
    input  logic [t4te_pkg::APB_W-1:0]         pwdata,
    output logic [t4te_pkg::APB_W-1:0]         prdata,
    output logic                               pready,

    input  logic                               tile_valid,
    output logic                               tile_stall,
    input  logic [t4te_pkg::LINE_W-1:0]        tile_line,
    input  logic [t4te_pkg::LINE_W-1:0]        partner_line,

    output logic                               result_valid,
    input  logic                               result_stall,
    output logic [t4te_pkg::LINE_W-1:0]        result_line,
    output logic                               last_line
);

    localparam int IDX_W = $clog2(TILE_LINES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TILE_LINES - 1);

    typedef enum logic [1:0] {
        ST_LOAD = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t                        state_reg, state_next;
    logic [t4te_pkg::MODE_W-1:0]   mode_reg;
    logic [t4te_pkg::SHIFT_W-1:0]  shift_reg;
    t4te_pkg::tile_cfg_t           tile_cfg_reg;
    logic [IDX_W-1:0]              load_cnt_reg;
    logic [IDX_W-1:0]              emit_cnt_reg;
    logic                          out_valid_reg;
    logic                          out_last_reg;
    logic [t4te_pkg::LINE_W-1:0]   out_line_reg;

    logic                          cfg_write;
    logic                          tile_accept;
    logic                          tile_done;
    logic                          out_free;
    logic                          emit_step;
    logic                          flip_vert;
    t4te_pkg::cell_ctrl_t          cell_ctrl;
    logic [t4te_pkg::LINE_W-1:0]   xf_result;

    logic [t4te_pkg::LINE_W-1:0]   cell_line    [TILE_LINES];
    logic [t4te_pkg::LINE_W-1:0]   cell_partner [TILE_LINES];

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= t4te_pkg::MODE_PASS;
            shift_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                t4te_pkg::REG_MODE:  mode_reg  <= pwdata[t4te_pkg::MODE_W-1:0];
                t4te_pkg::REG_SHIFT: shift_reg <= pwdata[t4te_pkg::SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            t4te_pkg::REG_MODE:  prdata = {{(t4te_pkg::APB_W-t4te_pkg::MODE_W){1'b0}}, mode_reg};
            t4te_pkg::REG_SHIFT: prdata = {{(t4te_pkg::APB_W-t4te_pkg::SHIFT_W){1'b0}}, shift_reg};
            default:             prdata = '0;
        endcase
    end

    // Control.
    assign tile_stall  = (state_reg != ST_LOAD);
    assign tile_accept = tile_valid && !tile_stall;
    assign tile_done   = tile_accept && (load_cnt_reg == LAST_IDX);
    assign out_free    = !out_valid_reg || !result_stall;
    assign emit_step   = (state_reg == ST_EMIT) && out_free;
    assign flip_vert   = (tile_cfg_reg.mode == t4te_pkg::MODE_FLIP_V)
                      || (tile_cfg_reg.mode == t4te_pkg::MODE_FLIP_VH);

    always_comb
    begin
        cell_ctrl.shift_fwd = tile_accept || (emit_step && !flip_vert);
        cell_ctrl.shift_rev = emit_step && flip_vert;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: if (tile_done) state_next = ST_EMIT;
            ST_EMIT: if (emit_step && (emit_cnt_reg == LAST_IDX)) state_next = ST_LOAD;
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            load_cnt_reg  <= '0;
            emit_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
            tile_cfg_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (tile_accept)
                load_cnt_reg <= load_cnt_reg + 1'b1;
            if (tile_done)
            begin
                tile_cfg_reg.mode  <= mode_reg;
                tile_cfg_reg.shift <= shift_reg;
            end
            if (emit_step)
                emit_cnt_reg <= emit_cnt_reg + 1'b1;
            if (emit_step)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_step)
        begin
            out_line_reg <= xf_result;
            out_last_reg <= (emit_cnt_reg == LAST_IDX);
        end
    end

    // Cell chain: new lines enter at cell 0, so the first line of a tile ends
    // in the last cell and the last line in cell 0.
    for (genvar k = 0; k < TILE_LINES; k++)
    begin : g_cell
        logic [t4te_pkg::LINE_W-1:0] prev_l, prev_p, next_l, next_p;

        if (k == 0)
        begin : g_head
            assign prev_l = tile_line;
            assign prev_p = partner_line;
        end
        else
        begin : g_body
            assign prev_l = cell_line[k-1];
            assign prev_p = cell_partner[k-1];
        end

        if (k == TILE_LINES - 1)
        begin : g_tail
            assign next_l = '0;
            assign next_p = '0;
        end
        else
        begin : g_inner
            assign next_l = cell_line[k+1];
            assign next_p = cell_partner[k+1];
        end

        t4te_cell u_cell
        (
            .clk          (clk),
            .ctrl         (cell_ctrl),
            .prev_line    (prev_l),
            .prev_partner (prev_p),
            .next_line    (next_l),
            .next_partner (next_p),
            .line         (cell_line[k]),
            .partner      (cell_partner[k])
        );
    end

    t4te_xform u_xform
    (
        .cfg         (tile_cfg_reg),
        .fwd_line    (cell_line[TILE_LINES-1]),
        .fwd_partner (cell_partner[TILE_LINES-1]),
        .rev_line    (cell_line[0]),
        .result      (xf_result)
    );

    assign result_valid = out_valid_reg;
    assign result_line  = out_line_reg;
    assign last_line    = out_last_reg;

endmodule

// ===== hdl/t4te_checker.sv =====
module t4te_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              tile_valid,
    input  logic                              tile_stall,
    input  logic                              result_valid,
    input  logic                              result_stall,
    input  logic [t4te_pkg::LINE_W-1:0]       result_line,
    input  logic                              last_line
);

    logic       tile_acc;
    logic       res_acc;
    logic [2:0] in_cnt_reg;
    logic [2:0] out_cnt_reg;
    logic [4:0] pending_reg;
    logic [4:0] pending_next;

    assign tile_acc = tile_valid && !tile_stall;
    assign res_acc  = result_valid && !result_stall;

    always_comb
    begin
        pending_next = pending_reg;
        if (tile_acc && (in_cnt_reg == 3'd7))
            pending_next = pending_next + 5'd8;
        if (res_acc)
            pending_next = pending_next - 5'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_cnt_reg  <= '0;
            out_cnt_reg <= '0;
            pending_reg <= '0;
        end
        else
        begin
            if (tile_acc)
                in_cnt_reg <= in_cnt_reg + 3'd1;
            if (res_acc)
                out_cnt_reg <= out_cnt_reg + 3'd1;
            pending_reg <= pending_next;
        end
    end

    // The last flag marks exactly every eighth result transaction.
    a_last_on_eighth: assert property (@(posedge clk) disable iff (!rst_n)
        res_acc |-> (last_line == (out_cnt_reg == 3'd7)))
        else $error("last_line does not mark the eighth result of a tile");

    // A result is only offered when a completed tile still owes results.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (pending_reg != 5'd0))
        else $error("result offered with no completed tile outstanding");

    // Input is held off only between tiles, never in the middle of loading one.
    a_stall_between_tiles: assert property (@(posedge clk) disable iff (!rst_n)
        tile_stall |-> (in_cnt_reg == 3'd0))
        else $error("tile channel stalled partway through a tile");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(result_line)
                                           && $stable(last_line)))
        else $error("stalled result transaction changed");

endmodule

bind tile_4bpp_transform_engine t4te_checker u_t4te_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .tile_valid   (tile_valid),
    .tile_stall   (tile_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_line  (result_line),
    .last_line    (last_line)
);
